>>> sv/tkd_pkg.sv
// Shared types and constants for the terminal key decoder.
// Used by the front parser, the key queue, the back cursor unit and the top level.
`timescale 1ns / 1ps

package tkd_pkg;

  localparam int COORD_W = 10;
  localparam int BYTE_W  = 8;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_COLS = 2'd1;

  localparam logic [COORD_W-1:0] ROWS_RESET = 10'd24;
  localparam logic [COORD_W-1:0] COLS_RESET = 10'd80;

  // bytes seen on the terminal line
  localparam logic [BYTE_W-1:0] CH_ESC      = 8'h1b;
  localparam logic [BYTE_W-1:0] CH_LBRACKET = 8'h5b;
  localparam logic [BYTE_W-1:0] CH_TILDE    = 8'h7e;
  localparam logic [BYTE_W-1:0] CH_O        = 8'h4f;
  localparam logic [BYTE_W-1:0] CTRL_MASK   = 8'h1f;
  localparam logic [BYTE_W-1:0] CH_Q        = 8'h71;
  localparam logic [BYTE_W-1:0] QUIT_BYTE   = CH_Q & CTRL_MASK;

  localparam logic [BYTE_W-1:0] CH_UA = 8'h41;  // 'A'
  localparam logic [BYTE_W-1:0] CH_UB = 8'h42;  // 'B'
  localparam logic [BYTE_W-1:0] CH_UC = 8'h43;  // 'C'
  localparam logic [BYTE_W-1:0] CH_UD = 8'h44;  // 'D'
  localparam logic [BYTE_W-1:0] CH_UF = 8'h46;  // 'F'
  localparam logic [BYTE_W-1:0] CH_UH = 8'h48;  // 'H'

  localparam logic [BYTE_W-1:0] CH_D0 = 8'h30;  // '0'
  localparam logic [BYTE_W-1:0] CH_D1 = 8'h31;
  localparam logic [BYTE_W-1:0] CH_D3 = 8'h33;
  localparam logic [BYTE_W-1:0] CH_D4 = 8'h34;
  localparam logic [BYTE_W-1:0] CH_D5 = 8'h35;
  localparam logic [BYTE_W-1:0] CH_D6 = 8'h36;
  localparam logic [BYTE_W-1:0] CH_D7 = 8'h37;
  localparam logic [BYTE_W-1:0] CH_D8 = 8'h38;
  localparam logic [BYTE_W-1:0] CH_D9 = 8'h39;

  typedef enum logic [3:0] {
    KEY_PLAIN = 4'd0,
    KEY_LEFT  = 4'd1,
    KEY_RIGHT = 4'd2,
    KEY_UP    = 4'd3,
    KEY_DOWN  = 4'd4,
    KEY_PGUP  = 4'd5,
    KEY_PGDN  = 4'd6,
    KEY_HOME  = 4'd7,
    KEY_END   = 4'd8,
    KEY_DEL   = 4'd9
  } key_code_t;

  // one decoded key, as it travels from parser to cursor unit
  typedef struct packed {
    key_code_t         key_code;
    logic [BYTE_W-1:0] key_byte;
    logic              quit;
  } key_ev_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

>>> sv/tkd_front.sv
// Front parser: accepts input beats and turns escape sequences and plain bytes into key events.
// Depends on tkd_pkg for byte constants and the key event type.
`timescale 1ns / 1ps

module tkd_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     accept,
  input  logic                     mode,
  input  logic [tkd_pkg::BYTE_W-1:0] data_byte,
  output logic                     push,
  output tkd_pkg::key_ev_t         push_ev
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ESC,
    PH_SKIP,
    PH_BRACKET,
    PH_O,
    PH_DIGIT
  } phase_t;

  phase_t                     phase_r, phase_nxt;
  logic [tkd_pkg::BYTE_W-1:0] digit_r, digit_nxt;

  tkd_pkg::key_code_t key;
  logic               emit;

  function automatic tkd_pkg::key_code_t bracket_letter(input logic [tkd_pkg::BYTE_W-1:0] b);
    tkd_pkg::key_code_t k;
    k = tkd_pkg::KEY_PLAIN;
    if (b == tkd_pkg::CH_UA) k = tkd_pkg::KEY_UP;
    else if (b == tkd_pkg::CH_UB) k = tkd_pkg::KEY_DOWN;
    else if (b == tkd_pkg::CH_UC) k = tkd_pkg::KEY_RIGHT;
    else if (b == tkd_pkg::CH_UD) k = tkd_pkg::KEY_LEFT;
    else if (b == tkd_pkg::CH_UH) k = tkd_pkg::KEY_HOME;
    else if (b == tkd_pkg::CH_UF) k = tkd_pkg::KEY_END;
    return k;
  endfunction

  function automatic tkd_pkg::key_code_t tilde_digit(input logic [tkd_pkg::BYTE_W-1:0] d);
    tkd_pkg::key_code_t k;
    k = tkd_pkg::KEY_PLAIN;
    if (d == tkd_pkg::CH_D1 || d == tkd_pkg::CH_D7) k = tkd_pkg::KEY_HOME;
    else if (d == tkd_pkg::CH_D3) k = tkd_pkg::KEY_DEL;
    else if (d == tkd_pkg::CH_D4 || d == tkd_pkg::CH_D8) k = tkd_pkg::KEY_END;
    else if (d == tkd_pkg::CH_D5) k = tkd_pkg::KEY_PGUP;
    else if (d == tkd_pkg::CH_D6) k = tkd_pkg::KEY_PGDN;
    return k;
  endfunction

  always_comb begin
    phase_nxt = phase_r;
    digit_nxt = digit_r;
    emit      = 1'b0;
    key       = tkd_pkg::KEY_PLAIN;
    push_ev.key_byte = tkd_pkg::CH_ESC;

    if (mode) begin
      // timeout: flush a pending escape as a plain ESC
      if (phase_r != PH_IDLE) emit = 1'b1;
    end else begin
      unique case (phase_r)
        PH_ESC: begin
          if (data_byte == tkd_pkg::CH_LBRACKET) phase_nxt = PH_BRACKET;
          else if (data_byte == tkd_pkg::CH_O) phase_nxt = PH_O;
          else phase_nxt = PH_SKIP;
        end
        PH_SKIP: begin
          emit = 1'b1;
        end
        PH_BRACKET: begin
          if (data_byte >= tkd_pkg::CH_D0 && data_byte <= tkd_pkg::CH_D9) begin
            digit_nxt = data_byte;
            phase_nxt = PH_DIGIT;
          end else begin
            emit = 1'b1;
            key  = bracket_letter(data_byte);
          end
        end
        PH_O: begin
          emit = 1'b1;
          if (data_byte == tkd_pkg::CH_UH) key = tkd_pkg::KEY_HOME;
          else if (data_byte == tkd_pkg::CH_UF) key = tkd_pkg::KEY_END;
        end
        PH_DIGIT: begin
          emit = 1'b1;
          if (data_byte == tkd_pkg::CH_TILDE) key = tilde_digit(digit_r);
        end
        default: begin
          if (data_byte == tkd_pkg::CH_ESC) begin
            phase_nxt = PH_ESC;
          end else begin
            emit = 1'b1;
            push_ev.key_byte = data_byte;
          end
        end
      endcase
    end

    if (emit) phase_nxt = PH_IDLE;
    if (key != tkd_pkg::KEY_PLAIN) push_ev.key_byte = '0;
    push_ev.key_code = key;
    push_ev.quit     = (key == tkd_pkg::KEY_PLAIN) && (push_ev.key_byte == tkd_pkg::QUIT_BYTE);
  end

  assign push = accept && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      digit_r <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      digit_r <= digit_nxt;
    end
  end

endmodule

>>> sv/tkd_queue.sv
// Short key-event queue between the front parser and the back cursor unit.
// Depends on tkd_pkg for the key event and status types.
`timescale 1ns / 1ps

module tkd_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  tkd_pkg::key_ev_t    push_ev,
  input  logic                pop,
  output tkd_pkg::key_ev_t    pop_ev,
  output tkd_pkg::q_status_t  status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  tkd_pkg::key_ev_t  mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign status.full  = (count_r == FULL_CNT);
  assign status.empty = (count_r == '0);
  assign pop_ev       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_ev;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !status.full || pop)
    else $error("key queue pushed while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !status.empty)
    else $error("key queue popped while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("key queue count beyond depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (status.empty || status.full) |-> (wr_ptr_r == rd_ptr_r))
    else $error("key queue pointers disagree with count");

endmodule

>>> sv/tkd_back.sv
// Back cursor unit: pops key events, applies cursor moves and holds the result register.
// Depends on tkd_pkg for the key event type and coordinate width.
`timescale 1ns / 1ps

module tkd_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [tkd_pkg::COORD_W-1:0]  screen_rows,
  input  logic [tkd_pkg::COORD_W-1:0]  screen_cols,
  input  tkd_pkg::q_status_t           q_status,
  input  tkd_pkg::key_ev_t             pop_ev,
  output logic                         pop,
  input  logic                         out_stall,
  output logic                         out_valid,
  output tkd_pkg::key_ev_t             out_ev,
  output logic [tkd_pkg::COORD_W-1:0]  out_col,
  output logic [tkd_pkg::COORD_W-1:0]  out_row
);

  logic                        valid_r;
  tkd_pkg::key_ev_t            ev_r;
  logic [tkd_pkg::COORD_W-1:0] col_r, col_nxt;
  logic [tkd_pkg::COORD_W-1:0] row_r, row_nxt;

  // advance when the result register is empty or being taken
  assign pop = !q_status.empty && (!valid_r || !out_stall);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    unique case (pop_ev.key_code)
      tkd_pkg::KEY_LEFT:  if (col_r != '0) col_nxt = col_r - 1'b1;
      tkd_pkg::KEY_RIGHT: if (col_r < screen_cols) col_nxt = col_r + 1'b1;
      tkd_pkg::KEY_UP:    if (row_r != '0) row_nxt = row_r - 1'b1;
      tkd_pkg::KEY_DOWN:  if (row_r < screen_rows) row_nxt = row_r + 1'b1;
      tkd_pkg::KEY_HOME:  col_nxt = '0;
      tkd_pkg::KEY_END:   col_nxt = screen_cols;
      tkd_pkg::KEY_PGUP:  row_nxt = (row_r > screen_rows) ? row_r - screen_rows : '0;
      tkd_pkg::KEY_PGDN:  if (row_r < screen_rows) row_nxt = screen_rows;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      col_r   <= '0;
      row_r   <= '0;
    end else begin
      if (pop) begin
        valid_r <= 1'b1;
        col_r   <= col_nxt;
        row_r   <= row_nxt;
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) ev_r <= pop_ev;
  end

  assign out_valid = valid_r;
  assign out_ev    = ev_r;
  assign out_col   = col_r;
  assign out_row   = row_r;

endmodule

>>> sv/terminal_key_decoder_cursor_top.sv
// Top level of the terminal key decoder with cursor tracking.
// Depends on tkd_pkg, tkd_front, tkd_queue and tkd_back.
//
// Usage: the input channel carries one terminal event per beat: in_mode 0 with a
// received byte in in_data_byte, or in_mode 1 for a read timeout. Beats move on
// valid high and stall low. Escape sequences (ESC [ letter, ESC [ digit ~,
// ESC O letter) come out as one key beat on the out_ channel; bytes that open or
// continue a sequence, and a timeout while idle, produce no beat. Each key beat
// carries the cursor column and row after that key is applied.
// The cfg_ channel writes screen_rows (index 0) and screen_cols (index 1); it is
// always ready and should only be written while the block is idle.
// Throughput: one input beat per cycle while in_stall is low. The front parser
// pushes events into a QUEUE_DEPTH-entry queue; the back unit pops one per cycle
// into the output register while that register is empty or being taken. When the
// receiver holds out_stall the queue fills and in_stall rises once it is full.
// Reset clears the parser, queue, cursor and output valid, and loads screen_rows = 24,
// screen_cols = 80.
`timescale 1ns / 1ps

module terminal_key_decoder_cursor_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_mode,
  input  logic [tkd_pkg::BYTE_W-1:0]      in_data_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [3:0]                      out_key_code,
  output logic [tkd_pkg::BYTE_W-1:0]      out_key_byte,
  output logic                            out_quit,
  output logic [tkd_pkg::COORD_W-1:0]     out_cursor_col,
  output logic [tkd_pkg::COORD_W-1:0]     out_cursor_row,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tkd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tkd_pkg::COORD_W-1:0]     cfg_data
);

  logic [tkd_pkg::COORD_W-1:0] rows_r, cols_r;
  logic                        accept;
  logic                        push, pop;
  tkd_pkg::key_ev_t            push_ev, pop_ev, out_ev;
  tkd_pkg::q_status_t          q_status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= tkd_pkg::ROWS_RESET;
      cols_r <= tkd_pkg::COLS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == tkd_pkg::CFG_SCREEN_ROWS) rows_r <= cfg_data;
      else if (cfg_index == tkd_pkg::CFG_SCREEN_COLS) cols_r <= cfg_data;
    end
  end

  assign in_stall = q_status.full;
  assign accept   = in_valid && !in_stall;

  tkd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .mode      (in_mode),
    .data_byte (in_data_byte),
    .push      (push),
    .push_ev   (push_ev)
  );

  tkd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_ev (push_ev),
    .pop     (pop),
    .pop_ev  (pop_ev),
    .status  (q_status)
  );

  tkd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .screen_rows (rows_r),
    .screen_cols (cols_r),
    .q_status    (q_status),
    .pop_ev      (pop_ev),
    .pop         (pop),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_ev      (out_ev),
    .out_col     (out_cursor_col),
    .out_row     (out_cursor_row)
  );

  assign out_key_code = out_ev.key_code;
  assign out_key_byte = out_ev.key_byte;
  assign out_quit     = out_ev.quit;

endmodule
